// File: design/kdl_pkg.sv
// Package for the key debounce and LED flasher block.
// Holds the request, result and configuration types and the named codes.
// No dependencies.
`default_nettype none

package kdl_pkg;

	localparam int unsigned TimeW   = 32;
	localparam int unsigned ColorW  = 24;
	localparam int unsigned LevelW  = 8;
	localparam int unsigned PeriodW = 16;
	localparam int unsigned CountW  = 8;
	localparam int unsigned CfgAddrW = 3;
	localparam int unsigned CfgDataW = 24;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_FLASH  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2
	} key_event_t;

	typedef enum logic [1:0] {
		SRC_OFF    = 2'd0,
		SRC_BASE   = 2'd1,
		SRC_ACCENT = 2'd2
	} led_src_t;

	localparam logic [CfgAddrW-1:0] REG_BASE_COLOR       = 3'd0;
	localparam logic [CfgAddrW-1:0] REG_BASE_INTENSITY   = 3'd1;
	localparam logic [CfgAddrW-1:0] REG_ACCENT_COLOR     = 3'd2;
	localparam logic [CfgAddrW-1:0] REG_ACCENT_INTENSITY = 3'd3;
	localparam logic [CfgAddrW-1:0] REG_DEBOUNCE_MS      = 3'd4;

	localparam logic [PeriodW-1:0] DebounceReset = 16'd50;

	typedef struct packed {
		logic               opcode;
		logic [TimeW-1:0]   now_ms;
		logic               raw_level;
		logic [CountW-1:0]  flash_limit;
		logic [PeriodW-1:0] flash_period_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        key_event;
		logic [ColorW-1:0] led_color;
		logic [LevelW-1:0] led_level;
		logic              flashing;
	} out_item_t;

endpackage

`default_nettype wire

// File: design/kdl_if.sv
// Channel interfaces for the key debounce and LED flasher block.
// Request, result and configuration write channels; depends on kdl_pkg.
`default_nettype none

interface kdl_in_if import kdl_pkg::*;;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface kdl_out_if import kdl_pkg::*;;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface kdl_cfg_if import kdl_pkg::*;;
	logic                valid;
	logic                ready;
	logic [CfgAddrW-1:0] addr;
	logic [CfgDataW-1:0] wdata;
	modport source (output valid, output addr, output wdata, input ready);
	modport sink (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

// File: design/key_debounce_led_flasher.sv
// Top level of the key debounce and LED flasher block.
// Depends on kdl_pkg and the channel interfaces in kdl_if.sv.
//
//   channel  role  payload
//   in_ch    sink  opcode, now_ms, raw_level, flash_limit, flash_period_ms
//   out_ch   src   key_event, led_color, led_level, flashing
//   cfg_ch   sink  addr (register index), wdata
//
// A request is captured in an input register; the key and flash logic runs on
// it and, when the result register can take it, updates the state and loads
// the result register, which drives out_ch. One request per cycle is sustained
// while the result side takes every result.
// A stall on the result side holds the input stage, and in_ch.ready drops only
// when both stages are full. Reset clears the block state and the valid flags;
// debounce_ms resets to 50 and the other registers to 0.
`default_nettype none

module key_debounce_led_flasher import kdl_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	kdl_in_if.sink     in_ch,
	kdl_out_if.source  out_ch,
	kdl_cfg_if.sink    cfg_ch
);

	// Configuration registers
	logic [ColorW-1:0]  base_color_q;
	logic [LevelW-1:0]  base_int_q;
	logic [ColorW-1:0]  accent_color_q;
	logic [LevelW-1:0]  accent_int_q;
	logic [PeriodW-1:0] debounce_q;

	// Block state
	logic               key_pressed_q;
	logic [TimeW-1:0]   last_change_q;
	logic [PeriodW-1:0] blink_period_q;
	logic [CountW-1:0]  blink_limit_q;
	logic [CountW-1:0]  blink_count_q;
	logic [TimeW-1:0]   last_blink_q;
	led_src_t           led_src_q;
	logic [LevelW-1:0]  led_int_q;

	// Pipeline
	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t res_s2;
	logic      adv_s1;

	// Next state
	logic               key_pressed_n;
	logic [TimeW-1:0]   last_change_n;
	logic [PeriodW-1:0] blink_period_n;
	logic [CountW-1:0]  blink_limit_n;
	logic [CountW-1:0]  blink_count_n;
	logic [TimeW-1:0]   last_blink_n;
	led_src_t           led_src_n;
	logic [LevelW-1:0]  led_int_n;
	key_event_t         event_n;
	logic [ColorW-1:0]  color_n;
	logic               pressed;
	logic [TimeW-1:0]   since_change;
	logic [TimeW-1:0]   since_blink;

	assign adv_s1       = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || adv_s1;
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = valid_s2;
	assign out_ch.data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_color_q   <= '0;
			base_int_q     <= '0;
			accent_color_q <= '0;
			accent_int_q   <= '0;
			debounce_q     <= DebounceReset;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.addr)
				REG_BASE_COLOR:       base_color_q   <= cfg_ch.wdata[ColorW-1:0];
				REG_BASE_INTENSITY:   base_int_q     <= cfg_ch.wdata[LevelW-1:0];
				REG_ACCENT_COLOR:     accent_color_q <= cfg_ch.wdata[ColorW-1:0];
				REG_ACCENT_INTENSITY: accent_int_q   <= cfg_ch.wdata[LevelW-1:0];
				REG_DEBOUNCE_MS:      debounce_q     <= cfg_ch.wdata[PeriodW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= in_ch.data;
		end
	end

	always_comb begin
		key_pressed_n  = key_pressed_q;
		last_change_n  = last_change_q;
		blink_period_n = blink_period_q;
		blink_limit_n  = blink_limit_q;
		blink_count_n  = blink_count_q;
		last_blink_n   = last_blink_q;
		led_src_n      = led_src_q;
		led_int_n      = led_int_q;
		event_n        = EV_NONE;
		pressed        = !item_s1.raw_level;
		since_change   = item_s1.now_ms - last_change_q;
		since_blink    = item_s1.now_ms - last_blink_q;

		if (item_s1.opcode == OP_FLASH) begin
			blink_limit_n  = item_s1.flash_limit;
			blink_count_n  = '0;
			blink_period_n = item_s1.flash_period_ms;
			last_blink_n   = item_s1.now_ms;
		end else begin
			if (pressed != key_pressed_q && since_change > TimeW'(debounce_q)) begin
				key_pressed_n = pressed;
				last_change_n = item_s1.now_ms;
				if (pressed) begin
					led_src_n = SRC_ACCENT;
					led_int_n = accent_int_q;
					event_n   = EV_PRESS;
				end else begin
					if (led_int_q > base_int_q && blink_period_q == '0) begin
						led_src_n = SRC_BASE;
						led_int_n = base_int_q;
					end
					event_n = EV_RELEASE;
				end
			end
			// The flash step sees the LED as the key step just left it.
			if (blink_period_q != '0 && since_blink > TimeW'(blink_period_q)) begin
				if (blink_limit_q != '0 && blink_count_q >= blink_limit_q) begin
					blink_period_n = '0;
					led_src_n      = SRC_BASE;
					led_int_n      = base_int_q;
				end else begin
					if (led_int_n > base_int_q) begin
						led_src_n = SRC_BASE;
						led_int_n = base_int_q;
					end else begin
						led_src_n     = SRC_ACCENT;
						led_int_n     = accent_int_q;
						blink_count_n = blink_count_q + 1'b1;
					end
					last_blink_n = item_s1.now_ms;
				end
			end
		end

		unique case (led_src_n)
			SRC_BASE:   color_n = base_color_q;
			SRC_ACCENT: color_n = accent_color_q;
			default:    color_n = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pressed_q  <= 1'b0;
			last_change_q  <= '0;
			blink_period_q <= '0;
			blink_limit_q  <= '0;
			blink_count_q  <= '0;
			last_blink_q   <= '0;
			led_src_q      <= SRC_OFF;
			led_int_q      <= '0;
		end else if (adv_s1) begin
			key_pressed_q  <= key_pressed_n;
			last_change_q  <= last_change_n;
			blink_period_q <= blink_period_n;
			blink_limit_q  <= blink_limit_n;
			blink_count_q  <= blink_count_n;
			last_blink_q   <= last_blink_n;
			led_src_q      <= led_src_n;
			led_int_q      <= led_int_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ch.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2.key_event <= event_n;
			res_s2.led_color <= color_n;
			res_s2.led_level <= led_int_n;
			res_s2.flashing  <= (blink_period_n != '0);
		end
	end

endmodule

`default_nettype wire

// File: verif/tb_key_debounce_led_flasher.sv
`timescale 1ns / 1ps
// Self-checking testbench for key_debounce_led_flasher: directed table, then random phases.
// Predicts each result in-line and compares it with the block's output in order.
// Depends on kdl_pkg, the channel interfaces in kdl_if.sv and the block's top level.

module tb_key_debounce_led_flasher;
	import kdl_pkg::*;

	localparam int CycleLimit   = 200000;
	localparam int ReportLimit  = 10;
	localparam int NumDirRows   = 25;
	localparam int DirResetRows = 3;
	localparam int PhaseItems   = 100;
	localparam int NumPhases    = 5;
	localparam int HoldCycles   = 300;
	localparam int TailCycles   = 8;

	typedef struct packed {
		in_item_t  req;
		logic      typed;
		out_item_t want;
	} dir_row_t;

	localparam out_item_t NoWant = '0;

	// The first rows run with the reset register values; the rest follow a register write.
	localparam dir_row_t DirRows [NumDirRows] = '{
		'{'{OP_SAMPLE, 32'd0,        1'b1, 8'h00, 16'h0000}, 1'b1, '{EV_NONE,  24'h0, 8'h0, 1'b0}},
		'{'{OP_SAMPLE, 32'd50,       1'b0, 8'h00, 16'h0000}, 1'b1, '{EV_NONE,  24'h0, 8'h0, 1'b0}},
		'{'{OP_SAMPLE, 32'd51,       1'b0, 8'h00, 16'h0000}, 1'b1, '{EV_PRESS, 24'h0, 8'h0, 1'b0}},
		'{'{OP_SAMPLE, 32'd101,      1'b1, 8'h00, 16'h0000}, 1'b0, NoWant},
		'{'{OP_SAMPLE, 32'd102,      1'b1, 8'hFF, 16'hFFFF}, 1'b0, NoWant},
		'{'{OP_SAMPLE, 32'd200,      1'b0, 8'h00, 16'h0000}, 1'b0, NoWant},
		'{'{OP_SAMPLE, 32'd300,      1'b1, 8'h00, 16'h0000}, 1'b0, NoWant},
		'{'{OP_FLASH,  32'd300,      1'b0, 8'd2,  16'd10},   1'b0, NoWant},
		'{'{OP_SAMPLE, 32'd310,      1'b1, 8'h00, 16'h0000}, 1'b0, NoWant},
		'{'{OP_SAMPLE, 32'd311,      1'b1, 8'h00, 16'h0000}, 1'b0, NoWant},
		'{'{OP_SAMPLE, 32'd322,      1'b1, 8'h00, 16'h0000}, 1'b0, NoWant},
		'{'{OP_SAMPLE, 32'd333,      1'b1, 8'h00, 16'h0000}, 1'b0, NoWant},
		'{'{OP_SAMPLE, 32'd344,      1'b1, 8'h00, 16'h0000}, 1'b0, NoWant},
		'{'{OP_FLASH,  32'd400,      1'b1, 8'd0,  16'd1},    1'b0, NoWant},
		'{'{OP_SAMPLE, 32'd402,      1'b0, 8'h00, 16'h0000}, 1'b0, NoWant},
		'{'{OP_FLASH,  32'd500,      1'b1, 8'd255, 16'd0},   1'b0, NoWant},
		'{'{OP_SAMPLE, 32'hFFFFFFFF, 1'b1, 8'h00, 16'h0000}, 1'b0, NoWant},
		'{'{OP_SAMPLE, 32'h00000010, 1'b0, 8'h00, 16'h0000}, 1'b0, NoWant},
		'{'{OP_SAMPLE, 32'h00000040, 1'b0, 8'h00, 16'h0000}, 1'b0, NoWant},
		'{'{OP_FLASH,  32'hFFFFFF00, 1'b0, 8'd255, 16'hFFFF}, 1'b0, NoWant},
		'{'{OP_SAMPLE, 32'h0000FFFF, 1'b0, 8'h00, 16'h0000}, 1'b0, NoWant},
		'{'{OP_FLASH,  32'h00000000, 1'b1, 8'd1,  16'd1},    1'b0, NoWant},
		'{'{OP_SAMPLE, 32'h00000002, 1'b0, 8'h00, 16'h0000}, 1'b0, NoWant},
		'{'{OP_SAMPLE, 32'h00000004, 1'b1, 8'h00, 16'h0000}, 1'b0, NoWant},
		'{'{OP_SAMPLE, 32'h00000006, 1'b1, 8'h00, 16'h0000}, 1'b0, NoWant}
	};

	logic clk;
	logic arst_n;

	kdl_in_if  in_ch ();
	kdl_out_if out_ch ();
	kdl_cfg_if cfg_ch ();

	key_debounce_led_flasher u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// Register copies seen by the predictor.
	logic [ColorW-1:0]  base_rgb;
	logic [LevelW-1:0]  base_lvl;
	logic [ColorW-1:0]  accent_rgb;
	logic [LevelW-1:0]  accent_lvl;
	logic [PeriodW-1:0] debounce_lim;

	// Predicted block state.
	logic               key_down;
	logic [TimeW-1:0]   last_change_ms;
	logic [PeriodW-1:0] blink_per;
	logic [CountW-1:0]  blink_lim;
	logic [CountW-1:0]  blink_cnt;
	logic [TimeW-1:0]   last_blink_ms;
	led_src_t           led_src;
	logic [LevelW-1:0]  led_int;

	out_item_t pending_results [$];
	out_item_t seen_item;
	out_item_t due_item;

	int src_idle_pct;
	int sink_stall_pct;
	int hold_left;
	int cycle_count;
	int fail_count;
	int n_requests;
	int n_results;
	int n_key_events;
	int n_flash_starts;
	int n_settings;

	logic [TimeW-1:0] sim_now;
	logic             key_raw;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("tb_key_debounce_led_flasher failed");
			$finish;
		end
	end

	function automatic void pick_base();
		led_src = SRC_BASE;
		led_int = base_lvl;
	endfunction

	function automatic void pick_accent();
		led_src = SRC_ACCENT;
		led_int = accent_lvl;
	endfunction

	function automatic void apply_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
		case (idx)
			REG_BASE_COLOR:       base_rgb = val[ColorW-1:0];
			REG_BASE_INTENSITY:   base_lvl = val[LevelW-1:0];
			REG_ACCENT_COLOR:     accent_rgb = val[ColorW-1:0];
			REG_ACCENT_INTENSITY: accent_lvl = val[LevelW-1:0];
			REG_DEBOUNCE_MS:      debounce_lim = val[PeriodW-1:0];
			default: ;
		endcase
	endfunction

	// Advances the key and LED state by one request and returns the result it produces.
	function automatic out_item_t advance_key_led(in_item_t req);
		out_item_t        res;
		logic             pressed;
		logic [TimeW-1:0] elapsed;
		res = '0;
		res.key_event = EV_NONE;
		if (req.opcode == OP_FLASH) begin
			blink_lim = req.flash_limit;
			blink_cnt = '0;
			blink_per = req.flash_period_ms;
			last_blink_ms = req.now_ms;
		end else begin
			pressed = ~req.raw_level;
			elapsed = req.now_ms - last_change_ms;
			if (pressed != key_down && elapsed > TimeW'(debounce_lim)) begin
				key_down = pressed;
				last_change_ms = req.now_ms;
				if (pressed) begin
					pick_accent();
					res.key_event = EV_PRESS;
				end else begin
					if (led_int > base_lvl && blink_per == '0)
						pick_base();
					res.key_event = EV_RELEASE;
				end
			end
			// The flash step sees the state left by the key handling above.
			elapsed = req.now_ms - last_blink_ms;
			if (blink_per != '0 && elapsed > TimeW'(blink_per)) begin
				if (blink_lim != '0 && blink_cnt >= blink_lim) begin
					blink_per = '0;
					pick_base();
				end else begin
					if (led_int > base_lvl) begin
						pick_base();
					end else begin
						pick_accent();
						blink_cnt = blink_cnt + 1'b1;
					end
					last_blink_ms = req.now_ms;
				end
			end
		end
		case (led_src)
			SRC_BASE:   res.led_color = base_rgb;
			SRC_ACCENT: res.led_color = accent_rgb;
			default:    res.led_color = '0;
		endcase
		res.led_level = led_int;
		res.flashing = (blink_per != '0);
		return res;
	endfunction

	// Mostly a running clock with small steps and a key that changes now and then;
	// a few jumps in time, some flash starts, and a few requests with every field random.
	function automatic in_item_t next_request();
		in_item_t req;
		int       pick;
		req = '0;
		pick = $urandom_range(99);
		req.raw_level = 1'($urandom_range(1));
		req.flash_limit = CountW'($urandom_range(255));
		req.flash_period_ms = PeriodW'($urandom_range(65535));
		if (pick < 5) begin
			req.opcode = 1'($urandom_range(1));
			req.now_ms = $urandom;
		end else begin
			if (pick < 8)
				sim_now = $urandom;
			else
				sim_now = sim_now + $urandom_range(20);
			req.now_ms = sim_now;
			if (pick >= 90) begin
				req.opcode = OP_FLASH;
				case ($urandom_range(9))
					0: req.flash_limit = '0;
					1: req.flash_limit = '1;
					default: req.flash_limit = CountW'($urandom_range(5, 1));
				endcase
				case ($urandom_range(9))
					0: req.flash_period_ms = '0;
					1: req.flash_period_ms = '1;
					2: req.flash_period_ms = PeriodW'($urandom_range(65535, 1));
					default: req.flash_period_ms = PeriodW'($urandom_range(15, 1));
				endcase
			end else begin
				req.opcode = OP_SAMPLE;
				if ($urandom_range(99) < 25)
					key_raw = ~key_raw;
				req.raw_level = key_raw;
			end
		end
		return req;
	endfunction

	// Offers one request, holding valid until it is taken, then records its expected result.
	task automatic push_request(in_item_t req, logic typed, out_item_t want);
		out_item_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= req;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predicted = advance_key_led(req);
		pending_results.push_back(typed ? want : predicted);
		n_requests++;
		if (predicted.key_event != EV_NONE)
			n_key_events++;
		if (req.opcode == OP_FLASH)
			n_flash_starts++;
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Writes all five registers and one index past the end, intensities with junk above bit 7.
	task automatic write_config(logic [ColorW-1:0] b_rgb, logic [LevelW-1:0] b_lvl,
			logic [ColorW-1:0] a_rgb, logic [LevelW-1:0] a_lvl, logic [PeriodW-1:0] deb);
		logic [CfgAddrW-1:0] idx [6];
		logic [CfgDataW-1:0] val [6];
		idx = '{REG_BASE_COLOR, REG_BASE_INTENSITY, REG_ACCENT_COLOR, REG_ACCENT_INTENSITY,
			REG_DEBOUNCE_MS, CfgAddrW'(REG_DEBOUNCE_MS + 1 + $urandom_range(2))};
		val = '{b_rgb, {16'($urandom), b_lvl}, a_rgb, {16'($urandom), a_lvl},
			{8'($urandom), deb}, CfgDataW'($urandom)};
		for (int i = 0; i < 6; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.addr <= idx[i];
			cfg_ch.wdata <= val[i];
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
			apply_reg(idx[i], val[i]);
		end
		cfg_ch.valid <= 1'b0;
		n_settings++;
	endtask

	// Result side: random stalls, plus a long hold-off when one is requested.
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			seen_item = out_ch.data;
			n_results++;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= ReportLimit)
					$display("result %0d arrived with no request pending: event %0d color %06h",
						n_results, seen_item.key_event, seen_item.led_color);
			end else begin
				due_item = pending_results.pop_front();
				if (seen_item.key_event !== due_item.key_event ||
						seen_item.led_color !== due_item.led_color ||
						seen_item.led_level !== due_item.led_level ||
						seen_item.flashing !== due_item.flashing) begin
					fail_count++;
					if (fail_count <= ReportLimit) begin
						$display("result %0d mismatch: expected event %0d color %06h level %02h flashing %0b",
							n_results, due_item.key_event, due_item.led_color,
							due_item.led_level, due_item.flashing);
						$display("  got event %0d color %06h level %02h flashing %0b",
							seen_item.key_event, seen_item.led_color, seen_item.led_level,
							seen_item.flashing);
					end
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.addr <= '0;
		cfg_ch.wdata <= '0;
		cycle_count = 0;
		fail_count = 0;
		n_requests = 0;
		n_results = 0;
		n_key_events = 0;
		n_flash_starts = 0;
		n_settings = 0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_left = 0;
		sim_now = '0;
		key_raw = 1'b1;
		base_rgb = '0;
		base_lvl = '0;
		accent_rgb = '0;
		accent_lvl = '0;
		debounce_lim = DebounceReset;
		key_down = 1'b0;
		last_change_ms = '0;
		blink_per = '0;
		blink_lim = '0;
		blink_cnt = '0;
		last_blink_ms = '0;
		led_src = SRC_OFF;
		led_int = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NumDirRows; i++) begin
			if (i == DirResetRows) begin
				drain_results();
				write_config(24'hFFFFFF, 8'h10, 24'h00FF00, 8'hF0, 16'd50);
			end
			push_request(DirRows[i].req, DirRows[i].typed, DirRows[i].want);
		end

		for (int p = 0; p < NumPhases; p++) begin
			drain_results();
			case (p)
				0: write_config(24'hFFFFFF, 8'hFF, 24'h000000, 8'h00, 16'd0);
				2: write_config(24'h000000, 8'h00, 24'hFFFFFF, 8'hFF, 16'hFFFF);
				default: write_config(ColorW'($urandom_range(24'hFFFFFF)),
					LevelW'($urandom_range(255)), ColorW'($urandom_range(24'hFFFFFF)),
					LevelW'($urandom_range(255)), PeriodW'($urandom_range(30)));
			endcase
			src_idle_pct = (p == 1) ? 84 : (p == 3) ? 15 : 0;
			sink_stall_pct = (p == 2) ? 84 : (p == 3) ? 15 : 0;
			// Last phase: the result side stops while requests keep coming, so the input stalls.
			if (p == NumPhases - 1)
				hold_left = HoldCycles;
			for (int i = 0; i < PhaseItems; i++)
				push_request(next_request(), 1'b0, NoWant);
		end

		drain_results();
		repeat (TailCycles) @(posedge clk);

		$display("covered %0d requests (%0d from the table), %0d results, %0d key events,",
			n_requests, NumDirRows, n_results, n_key_events);
		$display("%0d flash starts and %0d register settings; %0d mismatches, %0d left over",
			n_flash_starts, n_settings, fail_count, pending_results.size());
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("tb_key_debounce_led_flasher passed");
		end else begin
			$display("tb_key_debounce_led_flasher failed");
		end
		$finish;
	end

endmodule
